[design/mhv_pkg.sv]
// ----------------------------------------------------------------------------
// mhv_pkg
// Shared widths, types and codes for the microfacet half vector pipeline.
// ----------------------------------------------------------------------------
package mhv_pkg;

  // Direction fields: signed, DIR_FRAC_BITS fraction bits
  localparam int DIR_FRAC_BITS = 14;
  localparam int DIR_W  = 16;
  localparam int IOR_W  = 16;
  // Products and sums
  localparam int PROD_W = DIR_W + IOR_W + 1;        // signed eta * dir
  localparam int LN_W   = 2 * DIR_W + 2;            // dot of two directions
  localparam int S_W    = PROD_W + 1;               // sum vector component
  localparam int MAG_W  = S_W - 1;                  // its magnitude
  localparam int LEN_W  = 6;                        // leading-one position
  // Normalization
  localparam int NORM_W = 30;                       // top bit lands at NORM_W-1
  localparam int SQ_W   = 2 * NORM_W + 2;           // sum of three squares
  localparam int ROOT_W = SQ_W / 2;                 // integer square root
  localparam int Q_W    = DIR_FRAC_BITS + 1;        // quotient, at most 2^frac
  localparam int NUM_W  = NORM_W + DIR_FRAC_BITS + 1;

  // Command codes
  localparam logic CMD_REFLECT = 1'b0;
  localparam logic CMD_REFRACT = 1'b1;

  typedef logic [2:0][DIR_W-1:0] vec3_t;
  typedef logic [2:0][S_W-1:0]   sum3_t;
  typedef logic [2:0][Q_W-1:0]   quot3_t;

  // Side data that travels with an item through the root and divide stages
  typedef struct packed {
    logic                   nz;
    logic [2:0]             neg;
    logic [2:0][NORM_W-1:0] mag;
    vec3_t                  nvec;
  } carry_t;

endpackage

[design/mhv_sum.sv]
// ----------------------------------------------------------------------------
// mhv_sum
// Forms the sum vector: V+L for reflection, -etaT*V - etaI*L for refraction,
// with the indices swapped when L.N is negative. Four register stages.
// ----------------------------------------------------------------------------
module mhv_sum
  import mhv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  logic             cmd,
  input  vec3_t            vin,
  input  vec3_t            lin,
  input  vec3_t            nin,
  input  logic [IOR_W-1:0] ior_o,
  input  logic [IOR_W-1:0] ior_i,
  output logic             out_v,
  output sum3_t            s,
  output vec3_t            nout
);

  typedef struct packed {
    logic  cmd;
    vec3_t v;
    vec3_t l;
    vec3_t n;
  } item_t;

  logic v1, v2, v3;
  item_t a1, a2, a3;
  logic signed [2*DIR_W-1:0] lnp1 [3];
  logic [IOR_W-1:0] eta_i2, eta_t2;
  logic signed [PROD_W-1:0] pt3 [3];
  logic signed [PROD_W-1:0] pi3 [3];
  logic signed [LN_W-1:0] ln;
  logic swap;

  // L.N sum and swap decision
  always_comb begin
    ln = LN_W'(lnp1[0]) + LN_W'(lnp1[1]) + LN_W'(lnp1[2]);
    swap = ln[LN_W-1];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
      v2 <= v1;
      v3 <= v2;
      out_v <= v3;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= '{cmd: cmd, v: vin, l: lin, n: nin};
      for (int i = 0; i < 3; i++) begin
        lnp1[i] <= $signed(lin[i]) * $signed(nin[i]);
      end
      a2 <= a1;
      eta_i2 <= swap ? ior_i : ior_o;
      eta_t2 <= swap ? ior_o : ior_i;
      a3 <= a2;
      for (int i = 0; i < 3; i++) begin
        pt3[i] <= $signed({1'b0, eta_t2}) * $signed(a2.v[i]);
        pi3[i] <= $signed({1'b0, eta_i2}) * $signed(a2.l[i]);
      end
      nout <= a3.n;
      for (int i = 0; i < 3; i++) begin
        if (a3.cmd == CMD_REFRACT) begin
          s[i] <= -S_W'(pt3[i]) - S_W'(pi3[i]);
        end else begin
          s[i] <= S_W'($signed(a3.v[i])) + S_W'($signed(a3.l[i]));
        end
      end
    end
  end

endmodule

[design/mhv_norm.sv]
// ----------------------------------------------------------------------------
// mhv_norm
// Takes magnitudes, finds the leading one of the largest, shifts all three so
// it lands at the top of NORM_W bits, then squares and sums. Five stages.
// ----------------------------------------------------------------------------
module mhv_norm
  import mhv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_v,
  input  sum3_t             s,
  input  vec3_t             nin,
  output logic              out_v,
  output logic [SQ_W-1:0]   sq,
  output carry_t            cout
);

  localparam int WIDE_W = MAG_W + NORM_W;

  logic v1, v2, v3, v4;
  logic [MAG_W-1:0] mag1 [3];
  logic [MAG_W-1:0] mag2 [3];
  logic [2:0] neg1, neg2;
  logic nz1, nz2;
  vec3_t n1, n2;
  logic [LEN_W-1:0] len2;
  carry_t c3, c4;
  carry_t c3_next;
  logic [2*NORM_W-1:0] sqp4 [3];
  logic [MAG_W-1:0] orm;
  logic [LEN_W-1:0] len;
  logic [WIDE_W-1:0] wide [3];
  logic signed [S_W-1:0] si [3];

  // leading-one search over the OR of the magnitudes
  always_comb begin
    orm = mag1[0] | mag1[1] | mag1[2];
    len = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (orm[b]) len = LEN_W'(b + 1);
    end
  end

  // common shift of the three magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      si[i] = $signed(s[i]);
      if (len2 > LEN_W'(NORM_W)) begin
        wide[i] = WIDE_W'(mag2[i] >> (len2 - LEN_W'(NORM_W)));
      end else begin
        wide[i] = WIDE_W'(mag2[i]) << (LEN_W'(NORM_W) - len2);
      end
    end
    c3_next.nz = nz2;
    c3_next.neg = neg2;
    c3_next.nvec = n2;
    for (int i = 0; i < 3; i++) begin
      c3_next.mag[i] = wide[i][NORM_W-1:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_v <= v4;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= MAG_W'(si[i][S_W-1] ? -si[i] : si[i]);
        neg1[i] <= si[i][S_W-1];
      end
      nz1 <= |s;
      n1 <= nin;
      mag2 <= mag1;
      neg2 <= neg1;
      nz2 <= nz1;
      n2 <= n1;
      len2 <= len;
      c3 <= c3_next;
      c4 <= c3;
      for (int i = 0; i < 3; i++) begin
        sqp4[i] <= c3.mag[i] * c3.mag[i];
      end
      cout <= c4;
      sq <= SQ_W'(sqp4[0]) + SQ_W'(sqp4[1]) + SQ_W'(sqp4[2]);
    end
  end

endmodule

[design/mhv_sqrt.sv]
// ----------------------------------------------------------------------------
// mhv_sqrt
// Pipelined integer square root, one root bit per stage, ROOT_W stages.
// ----------------------------------------------------------------------------
module mhv_sqrt
  import mhv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_v,
  input  logic [SQ_W-1:0]   sq,
  input  carry_t            cin,
  output logic              out_v,
  output logic [ROOT_W-1:0] root,
  output carry_t            cout
);

  localparam int RW = SQ_W + 2;

  logic              vld [ROOT_W+1];
  logic [RW-1:0]     rem [ROOT_W+1];
  logic [ROOT_W-1:0] rt  [ROOT_W+1];
  carry_t            cs  [ROOT_W+1];

  assign vld[0] = in_v;
  assign rem[0] = RW'(sq);
  assign rt[0]  = '0;
  assign cs[0]  = cin;

  // stage j decides root bit ROOT_W-j
  for (genvar j = 1; j <= ROOT_W; j++) begin : g_step
    localparam int K = ROOT_W - j;
    logic [RW-1:0] trial;
    logic fit;

    assign trial = (RW'(rt[j-1]) << (K + 1)) + (RW'(1) << (2 * K));
    assign fit = rem[j-1] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= fit ? rem[j-1] - trial : rem[j-1];
        rt[j] <= fit ? (rt[j-1] | (ROOT_W'(1) << K)) : rt[j-1];
        cs[j] <= cs[j-1];
      end
    end
  end

  assign out_v = vld[ROOT_W];
  assign root  = rt[ROOT_W];
  assign cout  = cs[ROOT_W];

endmodule

[design/mhv_div.sv]
// ----------------------------------------------------------------------------
// mhv_div
// Three-lane pipelined restoring divider: (mag << frac + root/2) / root,
// one entry stage and one quotient bit per stage after it.
// ----------------------------------------------------------------------------
module mhv_div
  import mhv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_v,
  input  logic [ROOT_W-1:0] root,
  input  carry_t            cin,
  output logic              out_v,
  output quot3_t            q,
  output carry_t            cout
);

  logic                   vld [Q_W+1];
  logic [2:0][NUM_W-1:0]  rem [Q_W+1];
  quot3_t                 qt  [Q_W+1];
  logic [ROOT_W-1:0]      dv  [Q_W+1];
  carry_t                 cs  [Q_W+1];

  // entry stage: rounded numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= (NUM_W'(cin.mag[i]) << DIR_FRAC_BITS) + NUM_W'(root >> 1);
      end
      qt[0] <= '0;
      dv[0] <= root;
      cs[0] <= cin;
    end
  end

  // stage j decides quotient bit Q_W-j in all lanes
  for (genvar j = 1; j <= Q_W; j++) begin : g_step
    localparam int K = Q_W - j;
    logic [NUM_W:0] dsh;
    logic [2:0] fit;

    assign dsh = (NUM_W + 1)'(dv[j-1]) << K;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        fit[i] = (NUM_W + 1)'(rem[j-1][i]) >= dsh;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          rem[j][i] <= fit[i] ? rem[j-1][i] - dsh[NUM_W-1:0] : rem[j-1][i];
          qt[j][i] <= fit[i] ? (qt[j-1][i] | (Q_W'(1) << K)) : qt[j-1][i];
        end
        dv[j] <= dv[j-1];
        cs[j] <= cs[j-1];
      end
    end
  end

  assign out_v = vld[Q_W];
  assign q     = qt[Q_W];
  assign cout  = cs[Q_W];

endmodule

[design/mhv_orient.sv]
// ----------------------------------------------------------------------------
// mhv_orient
// Applies signs, tests H.N, flips H into the normal's hemisphere and zeroes
// degenerate results. Two stages.
// ----------------------------------------------------------------------------
module mhv_orient
  import mhv_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_v,
  input  quot3_t q,
  input  carry_t cin,
  output logic   out_v,
  output logic   made,
  output vec3_t  h
);

  logic v1;
  logic nz1;
  logic signed [DIR_W-1:0] h1 [3];
  logic signed [DIR_W-1:0] hs [3];
  logic signed [2*DIR_W-1:0] hp1 [3];
  logic signed [LN_W-1:0] d;
  logic made_next;

  // signed half vector components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hs[i] = cin.neg[i] ? -$signed(DIR_W'(q[i])) : $signed(DIR_W'(q[i]));
    end
  end

  // hemisphere dot product
  always_comb begin
    d = LN_W'(hp1[0]) + LN_W'(hp1[1]) + LN_W'(hp1[2]);
    made_next = nz1 && (d != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
      out_v <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nz1 <= cin.nz;
      for (int i = 0; i < 3; i++) begin
        h1[i] <= hs[i];
        hp1[i] <= hs[i] * $signed(cin.nvec[i]);
      end
      made <= made_next;
      for (int i = 0; i < 3; i++) begin
        if (!made_next) begin
          h[i] <= '0;
        end else if (d[LN_W-1]) begin
          h[i] <= -h1[i];
        end else begin
          h[i] <= h1[i];
        end
      end
    end
  end

endmodule

[design/microfacet_half_vector_core.sv]
// ----------------------------------------------------------------------------
// microfacet_half_vector_core
// Reflection / refraction half vector unit, one result per input item.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry command, view, light and normal.
// Output channel: out_valid / out_stall carry made and half_x/y/z.
// A transfer happens at a clock edge with valid high and stall low.
// Refractive indices ior_outer (0x0) and ior_inner (0x4) are written over the
// APB port; pready is tied high. The user must write them only while the unit
// is idle, which the block itself does not enforce. Items pass through 4 sum
// stages, 5 normalize stages, 31 square-root stages, 16 divide stages, 2
// orient stages and 1 output register. Throughput: one item per cycle while
// in_stall is low, set by the fully pipelined root and divider.
// When the receiver stalls, the output register holds and one more result
// goes to a skid register; the pipeline freezes only while the skid is full,
// and in_stall is high for exactly that time. Nothing is dropped or repeated.
// Synchronous reset empties the pipeline and output and loads the index
// registers with 1.0 (outer) and 1.5 (inner).
// ----------------------------------------------------------------------------
module microfacet_half_vector_core
  import mhv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [15:0] view_x,
  input  logic [15:0] view_y,
  input  logic [15:0] view_z,
  input  logic [15:0] light_x,
  input  logic [15:0] light_y,
  input  logic [15:0] light_z,
  input  logic [15:0] normal_x,
  input  logic [15:0] normal_y,
  input  logic [15:0] normal_z,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        made,
  output logic [15:0] half_x,
  output logic [15:0] half_y,
  output logic [15:0] half_z,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_IOR_OUTER = 1'b0;
  localparam logic REG_IOR_INNER = 1'b1;
  localparam logic [IOR_W-1:0] IOR_OUTER_RST = IOR_W'(4096);
  localparam logic [IOR_W-1:0] IOR_INNER_RST = IOR_W'(6144);

  logic [IOR_W-1:0] ior_outer, ior_inner;
  logic en;
  logic sum_v, norm_v, sqrt_v, div_v, p_v;
  sum3_t s;
  vec3_t n_sum;
  logic [SQ_W-1:0] sq;
  carry_t c_norm, c_sqrt, c_div;
  logic [ROOT_W-1:0] root;
  quot3_t q;
  logic p_made;
  vec3_t p_h;
  logic skid_v, skid_made;
  vec3_t skid_h;
  logic take;

  // configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IOR_INNER) ? 32'(ior_inner) : 32'(ior_outer);

  always_ff @(posedge clk) begin
    if (rst) begin
      ior_outer <= IOR_OUTER_RST;
      ior_inner <= IOR_INNER_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_IOR_OUTER: ior_outer <= pwdata[IOR_W-1:0];
        REG_IOR_INNER: ior_inner <= pwdata[IOR_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless the skid register is occupied
  assign en = !skid_v;
  assign in_stall = skid_v;

  mhv_sum u_sum (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (in_valid),
    .cmd   (command),
    .vin   ({view_z, view_y, view_x}),
    .lin   ({light_z, light_y, light_x}),
    .nin   ({normal_z, normal_y, normal_x}),
    .ior_o (ior_outer),
    .ior_i (ior_inner),
    .out_v (sum_v),
    .s     (s),
    .nout  (n_sum)
  );

  mhv_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (sum_v),
    .s     (s),
    .nin   (n_sum),
    .out_v (norm_v),
    .sq    (sq),
    .cout  (c_norm)
  );

  mhv_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (norm_v),
    .sq    (sq),
    .cin   (c_norm),
    .out_v (sqrt_v),
    .root  (root),
    .cout  (c_sqrt)
  );

  mhv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (sqrt_v),
    .root  (root),
    .cin   (c_sqrt),
    .out_v (div_v),
    .q     (q),
    .cout  (c_div)
  );

  mhv_orient u_orient (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (div_v),
    .q     (q),
    .cin   (c_div),
    .out_v (p_v),
    .made  (p_made),
    .h     (p_h)
  );

  // output register with one skid entry
  assign take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (take) begin
        skid_v <= 1'b0;
      end
    end else if (p_v) begin
      if (out_valid && !take) begin
        skid_v <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (take) begin
        made <= skid_made;
        {half_z, half_y, half_x} <= skid_h;
      end
    end else if (p_v) begin
      if (out_valid && !take) begin
        skid_made <= p_made;
        skid_h <= p_h;
      end else begin
        made <= p_made;
        {half_z, half_y, half_x} <= p_h;
      end
    end
  end

`ifndef ASSERT_OFF
  // skid only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid register full while output empty");

  // degenerate result carries a zero vector
  a_not_made_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !made) |-> (half_x == '0 && half_y == '0 && half_z == '0))
    else $error("half vector not zero on degenerate result");

  // a formed half vector is never zero
  a_made_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && made) |-> (half_x != '0 || half_y != '0 || half_z != '0))
    else $error("zero half vector flagged as made");

  // stall reaches the input only after a held result and a full skid
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall && p_v))
    else $error("input stalled without a held result");
`endif

endmodule
